// ===== design/eme_pkg.sv =====
// Shared types and constants for the private exponent derivation block.
package eme_pkg;

   localparam int PRIME_BITS = 32;
   localparam int WORD_BITS  = 64;
   localparam int CNT_BITS   = $clog2(WORD_BITS + 1);

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_INVERSE = 2'd1,
      STATUS_INVALID    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PHI,
      ST_CHECK,
      ST_REDUCE,
      ST_REDUCE_WAIT,
      ST_LOOP,
      ST_LOOP_WAIT,
      ST_FINAL,
      ST_FINAL_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [63:0] pub_exponent;
      logic [63:0] modulus;
      logic [31:0] prime_p;
      logic [31:0] prime_q;
   } req_type;

   typedef struct packed {
      logic [63:0] priv_exponent;
      logic [63:0] modulus_out;
      logic [63:0] gcd_value;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] dividend;
      logic [WORD_BITS-1:0] divisor;
      logic [WORD_BITS-1:0] mult;
   } div_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] remainder;
      logic [WORD_BITS-1:0] product;
   } div_rsp_type;

endpackage

// ===== design/rsa_private_exponent.sv =====
// Top level: derives d = e^-1 mod (p-1)(q-1) with the extended Euclidean algorithm.
// After acceptance the block forms phi, reduces e mod phi, then runs k Euclid steps
// (k up to about 93) and a final reduction before the result strobe; every step
// is one pass of the shared bit-serial divider. Without an inverse the final
// reduction is skipped. Zero phi finishes without any divider pass.
// Throughput: one item at a time; busy is high from acceptance through the result,
// and the next item is accepted in the cycle after the result at the earliest.
// Reset: synchronous, active high; returns the sequencer and divider to idle.
module rsa_private_exponent (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  eme_pkg::req_type req_data,
   output logic             rsp_valid,
   output eme_pkg::rsp_type rsp_data
);
   import eme_pkg::*;

   state_type            state_ff, state_in;
   logic [63:0]          e_ff, e_in;
   logic [63:0]          n_ff, n_in;
   logic [PRIME_BITS-1:0] p_ff, p_in, q_ff, q_in;
   logic [PRIME_BITS-1:0] pm1, qm1;
   logic [2*PRIME_BITS-1:0] phi_prod;
   logic [WORD_BITS-1:0] phi_ff, phi_in;
   logic [WORD_BITS-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [WORD_BITS-1:0] m0_ff, m0_in, m1_ff, m1_in;
   logic                 neg0_ff, neg0_in, neg1_ff, neg1_in;
   logic [WORD_BITS-1:0] d_ff, d_in, gcd_ff, gcd_in;
   status_type           status_ff, status_in;
   logic                 div_start;
   div_req_type          div_req;
   logic                 div_done;
   div_rsp_type          div_rsp;

   eme_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_req   (div_req),
      .div_done  (div_done),
      .div_rsp   (div_rsp)
   );

   assign pm1 = (p_ff == '0) ? '0 : p_ff - 1'b1;
   assign qm1 = (q_ff == '0) ? '0 : q_ff - 1'b1;

   // Full-width product of the two saturated primes minus one.
   assign phi_prod = pm1 * qm1;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:        if (start) state_in = ST_PHI;
         ST_PHI:         state_in = ST_CHECK;
         ST_CHECK:       state_in = (phi_ff == '0) ? ST_DONE : ST_REDUCE;
         ST_REDUCE:      state_in = ST_REDUCE_WAIT;
         ST_REDUCE_WAIT: if (div_done) state_in = ST_LOOP;
         ST_LOOP:        state_in = (r1_ff == '0) ? ST_FINAL : ST_LOOP_WAIT;
         ST_LOOP_WAIT:   if (div_done) state_in = ST_LOOP;
         ST_FINAL:       state_in = (r0_ff == WORD_BITS'(1)) ? ST_FINAL_WAIT : ST_DONE;
         ST_FINAL_WAIT:  if (div_done) state_in = ST_DONE;
         ST_DONE:        state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // Divider requests and handshake outputs.
   always_comb begin
      div_start = 1'b0;
      div_req   = '0;
      case (state_ff)
         ST_REDUCE: begin
            div_start        = 1'b1;
            div_req.dividend = e_ff;
            div_req.divisor  = phi_ff;
         end
         ST_LOOP: begin
            div_start        = (r1_ff != '0);
            div_req.dividend = r0_ff;
            div_req.divisor  = r1_ff;
            div_req.mult     = m1_ff;
         end
         ST_FINAL: begin
            div_start        = (r0_ff == WORD_BITS'(1));
            div_req.dividend = m0_ff;
            div_req.divisor  = phi_ff;
         end
         default: div_start = 1'b0;
      endcase
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      rsp_data.priv_exponent = d_ff;
      rsp_data.modulus_out   = n_ff;
      rsp_data.gcd_value     = gcd_ff;
      rsp_data.status        = status_ff;
   end

   // Datapath register updates.
   always_comb begin
      e_in = e_ff; n_in = n_ff; p_in = p_ff; q_in = q_ff; phi_in = phi_ff;
      r0_in = r0_ff; r1_in = r1_ff; m0_in = m0_ff; m1_in = m1_ff;
      neg0_in = neg0_ff; neg1_in = neg1_ff;
      d_in = d_ff; gcd_in = gcd_ff; status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            e_in = req_data.pub_exponent;
            n_in = req_data.modulus;
            p_in = req_data.prime_p[PRIME_BITS-1:0];
            q_in = req_data.prime_q[PRIME_BITS-1:0];
         end
         ST_PHI: phi_in = WORD_BITS'(phi_prod);
         ST_CHECK: begin
            d_in      = '0;
            gcd_in    = e_ff;
            status_in = STATUS_INVALID;
         end
         ST_REDUCE_WAIT: begin
            r0_in = phi_ff; r1_in = div_rsp.remainder;
            m0_in = '0; m1_in = WORD_BITS'(1);
            neg0_in = 1'b0; neg1_in = 1'b0;
         end
         ST_LOOP_WAIT: if (div_done) begin
            r0_in   = r1_ff;
            r1_in   = div_rsp.remainder;
            m0_in   = m1_ff;
            m1_in   = m0_ff + div_rsp.product;
            neg0_in = neg1_ff;
            neg1_in = !neg1_ff;
         end
         ST_FINAL: begin
            gcd_in    = r0_ff;
            d_in      = '0;
            status_in = (r0_ff == WORD_BITS'(1)) ? STATUS_OK : STATUS_NO_INVERSE;
         end
         ST_FINAL_WAIT: begin
            d_in = (neg0_ff && div_rsp.remainder != '0) ?
                   phi_ff - div_rsp.remainder : div_rsp.remainder;
         end
         default: d_in = d_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      e_ff <= e_in; n_ff <= n_in; p_ff <= p_in; q_ff <= q_in; phi_ff <= phi_in;
      r0_ff <= r0_in; r1_ff <= r1_in; m0_ff <= m0_in; m1_ff <= m1_in;
      neg0_ff <= neg0_in; neg1_ff <= neg1_in;
      d_ff <= d_in; gcd_ff <= gcd_in; status_ff <= status_in;
   end

   // An accepted item makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

   // After a result the block is free again.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("block stayed busy after a result");

   // A successful inverse always comes with a gcd of one.
   a_ok_gcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK |-> rsp_data.gcd_value == 64'd1)
      else $error("status ok with gcd other than one");

   // An error result carries a zero exponent.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.priv_exponent == '0)
      else $error("error result with nonzero exponent");

endmodule

// ===== design/eme_divider.sv =====
// Bit-serial restoring divider that also forms quotient times a multiplicand.
module eme_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 div_start,
   input  eme_pkg::div_req_type div_req,
   output logic                 div_done,
   output eme_pkg::div_rsp_type div_rsp
);
   import eme_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] dvd_ff, dvd_in;
   logic [WORD_BITS-1:0] dvs_ff, dvs_in;
   logic [WORD_BITS-1:0] mult_ff, mult_in;
   logic [WORD_BITS-1:0] prod_ff, prod_in;
   logic [WORD_BITS:0]   trial;
   logic [WORD_BITS:0]   diff;
   logic                 qbit;

   // One quotient bit per cycle, most significant first; the product
   // accumulates as a shift-and-add of the multiplicand (modulo 2^64).
   always_comb begin
      trial    = {rem_ff, dvd_ff[WORD_BITS-1]};
      diff     = trial - {1'b0, dvs_ff};
      qbit     = !diff[WORD_BITS];
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      mult_in  = mult_ff;
      prod_in  = prod_ff;
      if (div_start && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(WORD_BITS);
         rem_in   = '0;
         prod_in  = '0;
         dvd_in   = div_req.dividend;
         dvs_in   = div_req.divisor;
         mult_in  = div_req.mult;
      end else if (busy_ff) begin
         rem_in   = qbit ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
         dvd_in   = {dvd_ff[WORD_BITS-2:0], 1'b0};
         prod_in  = {prod_ff[WORD_BITS-2:0], 1'b0} + (qbit ? mult_ff : '0);
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      mult_ff <= mult_in;
      prod_ff <= prod_in;
   end

   assign div_done          = done_ff;
   assign div_rsp.remainder = rem_ff;
   assign div_rsp.product   = prod_ff;

endmodule

// ===== bench/tb_rsa_private_exponent.sv =====
// Testbench for rsa_private_exponent: directed and random keys checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_rsa_private_exponent;
   import eme_pkg::*;

   localparam int WATCHDOG_CYCLES = 40000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type expected_keys[$];
   int      error_count = 0;
   int      idle_cycles = 0;

   rsa_private_exponent uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // Computes the private exponent, gcd and status for one item.
   function automatic rsp_type derive_key(req_type item);
      rsp_type res;
      logic [63:0] pm, qm, phi, r0, r1, m0, m1, quo, tmp, d;
      logic neg0, neg1, ntmp;
      pm = 64'(item.prime_p[PRIME_BITS-1:0]);
      qm = 64'(item.prime_q[PRIME_BITS-1:0]);
      pm = (pm == 0) ? 64'd0 : pm - 1;
      qm = (qm == 0) ? 64'd0 : qm - 1;
      phi = pm * qm;
      res.modulus_out = item.modulus;
      if (phi == 0) begin
         res.priv_exponent = '0;
         res.gcd_value = item.pub_exponent;
         res.status = STATUS_INVALID;
         return res;
      end
      r0 = phi;
      r1 = item.pub_exponent % phi;
      m0 = 0; neg0 = 0;
      m1 = 1; neg1 = 0;
      while (r1 != 0) begin
         quo = r0 / r1;
         tmp = r0 - quo * r1;
         r0 = r1;
         r1 = tmp;
         tmp = m0 + quo * m1;
         ntmp = !neg1;
         m0 = m1; neg0 = neg1;
         m1 = tmp; neg1 = ntmp;
      end
      res.gcd_value = r0;
      if (r0 != 1) begin
         res.priv_exponent = '0;
         res.status = STATUS_NO_INVERSE;
         return res;
      end
      d = m0 % phi;
      if (neg0 && d != 0) d = phi - d;
      res.priv_exponent = d;
      res.status = STATUS_OK;
      return res;
   endfunction

   // Sends one item after a random gap, mostly short and sometimes long, and holds start
   // until the block is no longer busy, so items never overlap.
   task automatic send_key(input req_type item);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) gap = 1;
      repeat (gap) @(posedge clock);
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_keys.push_back(derive_key(item));
      start <= 1'b0;
      req_data <= '0;
   endtask

   // Every result is compared with the oldest expectation, or flagged if none is pending.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_keys.size() == 0) begin
            $error("result with no expectation pending");
            error_count++;
         end else begin
            want = expected_keys.pop_front();
            if (rsp_data.priv_exponent !== want.priv_exponent) begin
               $error("priv_exponent expected %h actual %h",
                      want.priv_exponent, rsp_data.priv_exponent);
               error_count++;
            end
            if (rsp_data.modulus_out !== want.modulus_out) begin
               $error("modulus_out expected %h actual %h",
                      want.modulus_out, rsp_data.modulus_out);
               error_count++;
            end
            if (rsp_data.gcd_value !== want.gcd_value) begin
               $error("gcd_value expected %h actual %h",
                      want.gcd_value, rsp_data.gcd_value);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted item or result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic req_type make_key(logic [63:0] e, logic [31:0] p, logic [31:0] q);
      req_type item;
      item.pub_exponent = e;
      item.modulus = {$urandom, $urandom};
      item.prime_p = p;
      item.prime_q = q;
      return item;
   endfunction

   // Primes below two, phi of one, exponent multiples and field extremes.
   task automatic test_special_cases();
      send_key(make_key(64'd65537, 32'd0, 32'd11));
      send_key(make_key(64'hFFFF_FFFF_FFFF_FFFF, 32'd13, 32'd1));
      send_key(make_key(64'd0, 32'd1, 32'd0));
      send_key(make_key(64'd5, 32'd2, 32'd2));
      send_key(make_key(64'd0, 32'd2, 32'd2));
      send_key(make_key(64'd40, 32'd11, 32'd5));
      send_key(make_key(64'd0, 32'd11, 32'd5));
      send_key(make_key(64'd6, 32'd11, 32'd5));
      send_key(make_key(64'd3, 32'd11, 32'd7));
      send_key(make_key(64'd65537, 32'd61, 32'd53));
      send_key(make_key(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB));
      send_key(make_key(64'd65537, 32'hFFFF_FFFB, 32'hFFFF_FFC5));
      send_key(make_key(64'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_key(make_key(64'hFFFF_FFFF_FFFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFF));
      send_key(make_key(64'd1, 32'd3, 32'd5));
   endtask

   // Waits until every expected result has arrived.
   task automatic drain_results();
      while (expected_keys.size() != 0) @(posedge clock);
   endtask

   // Random keys: mostly odd exponents below phi, some of any size.
   task automatic test_random_keys(input int count);
      logic [63:0] e;
      logic [31:0] p, q;
      for (int i = 0; i < count; i++) begin
         p = {$urandom} | 32'd1;
         q = {$urandom} | 32'd1;
         if ($urandom_range(0, 4) == 0) p = $urandom_range(0, 300);
         if ($urandom_range(0, 4) == 0) q = $urandom_range(0, 300);
         case ($urandom_range(0, 3))
            0: e = 64'd65537;
            1: e = {$urandom, $urandom};
            2: e = {32'd0, $urandom} | 64'd1;
            default: e = 64'($urandom_range(2, 1000));
         endcase
         send_key(make_key(e, p, q));
         if (i == count / 2) drain_results();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      drain_results();
      test_random_keys(125);
      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/eme_pkg.sv
design/eme_divider.sv
design/rsa_private_exponent.sv
bench/tb_rsa_private_exponent.sv
